@@ hw/rtl/mwta_pkg.sv @@
package mwta_pkg;

	// Field widths fixed by the stream format
	localparam int SAMPLE_IN_BITS = 32;
	localparam int AVG_BITS       = 32;
	localparam int SUM_BITS       = 40;

	// Trailing windows, shortest first; full_mask bit k belongs to WINDOW_LEN[k]
	localparam int NUM_WINDOWS = 6;
	localparam int WINDOW_LEN [NUM_WINDOWS] = '{3, 5, 10, 30, 60, 120};

	// Constant divider: a magnitude stage, then one 8-bit quotient digit per further pipeline stage
	localparam int DIGIT_BITS  = 8;
	localparam int NUM_DIGITS  = SUM_BITS / DIGIT_BITS;
	localparam int DIV_STAGES  = NUM_DIGITS + 1;
	localparam int RECIP_SHIFT = 22;

endpackage

@@ hw/rtl/mwta_if.sv @@
// Sample stream channel
interface mwta_in_if
	import mwta_pkg::*;
	();
	logic                             valid;
	logic                             ready;
	logic signed [SAMPLE_IN_BITS-1:0] sample;
	logic                             series_start;

	modport source (output valid, sample, series_start, input ready);
	modport sink   (input valid, sample, series_start, output ready);
endinterface

// Trailing average result channel
interface mwta_out_if
	import mwta_pkg::*;
	();
	logic                       valid;
	logic                       ready;
	logic signed [AVG_BITS-1:0] avg_w3;
	logic signed [AVG_BITS-1:0] avg_w5;
	logic signed [AVG_BITS-1:0] avg_w10;
	logic signed [AVG_BITS-1:0] avg_w30;
	logic signed [AVG_BITS-1:0] avg_w60;
	logic signed [AVG_BITS-1:0] avg_w120;
	logic [NUM_WINDOWS-1:0]     full_mask;

	modport source (output valid, avg_w3, avg_w5, avg_w10, avg_w30, avg_w60, avg_w120,
		full_mask, input ready);
	modport sink   (input valid, avg_w3, avg_w5, avg_w10, avg_w30, avg_w60, avg_w120,
		full_mask, output ready);
endinterface

@@ hw/rtl/mwta_div_lane.sv @@
// Pipelined signed divide by a constant, truncating toward zero.
// Stage 0 takes the magnitude, then one quotient digit per stage by
// long division; each digit is a small reciprocal multiply.
module mwta_div_lane
	import mwta_pkg::*;
	#(
		parameter int DIVISOR = 3
	)
	(
		input  logic                       clk,
		input  logic [DIV_STAGES-1:0]      stage_en,
		input  logic signed [SUM_BITS-1:0] sum,
		input  logic                       full,
		output logic signed [AVG_BITS-1:0] avg,
		output logic                       avg_full
	);

	localparam int RB    = $clog2(DIVISOR);
	localparam int XB    = RB + DIGIT_BITS;
	localparam int RECIP = ((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
	localparam int RECB  = $clog2(RECIP + 1);
	localparam int PB    = XB + RECB;

	logic [SUM_BITS-1:0] sum_u;
	logic [SUM_BITS-1:0] mag;

	logic [SUM_BITS-1:0] num_q  [NUM_DIGITS];
	logic [RB-1:0]       rem_q  [NUM_DIGITS];
	logic [AVG_BITS-1:0] quot_q [NUM_DIGITS];
	logic                neg_q  [NUM_DIGITS];
	logic                full_q [NUM_DIGITS];
	logic [AVG_BITS-1:0] avg_q;
	logic                avg_full_q;

	// Magnitude of the running sum
	assign sum_u = sum;
	assign mag   = sum_u[SUM_BITS-1] ? (~sum_u + 1'b1) : sum_u;

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			num_q[0]  <= mag;
			rem_q[0]  <= '0;
			quot_q[0] <= '0;
			neg_q[0]  <= sum_u[SUM_BITS-1];
			full_q[0] <= full;
		end
	end

	// One quotient digit per stage
	for (genvar j = 1; j <= NUM_DIGITS; j++) begin : g_digit
		logic [XB-1:0]         x;
		logic [PB-1:0]         prod;
		logic [DIGIT_BITS-1:0] qd;
		logic [XB-1:0]         back;
		logic [AVG_BITS-1:0]   quot_next;

		assign x         = {rem_q[j-1], num_q[j-1][SUM_BITS-1 -: DIGIT_BITS]};
		assign prod      = PB'(x) * PB'(RECIP);
		assign qd        = prod[RECIP_SHIFT +: DIGIT_BITS];
		assign back      = x - XB'(qd) * XB'(DIVISOR);
		assign quot_next = {quot_q[j-1][AVG_BITS-DIGIT_BITS-1:0], qd};

		if (j < NUM_DIGITS) begin : g_mid
			always_ff @(posedge clk) begin
				if (stage_en[j]) begin
					num_q[j]  <= num_q[j-1] << DIGIT_BITS;
					rem_q[j]  <= back[RB-1:0];
					quot_q[j] <= quot_next;
					neg_q[j]  <= neg_q[j-1];
					full_q[j] <= full_q[j-1];
				end
			end
		end else begin : g_last
			// Last digit: restore the sign; a window not yet full reads zero
			always_ff @(posedge clk) begin
				if (stage_en[j]) begin
					if (!full_q[j-1]) begin
						avg_q <= '0;
					end else if (neg_q[j-1]) begin
						avg_q <= ~quot_next + 1'b1;
					end else begin
						avg_q <= quot_next;
					end
					avg_full_q <= full_q[j-1];
				end
			end
		end
	end

	assign avg      = avg_q;
	assign avg_full = avg_full_q;

endmodule

@@ hw/rtl/multi_window_trailing_average_top.sv @@
// Trailing averages over 3, 5, 10, 30, 60 and 120 prior samples.
// A result passes the sum register, the magnitude stage and then the quotient digit stages.
// Throughput: one sample per cycle while the result channel is ready; set by the running-sum
// update (subtract the aged-out tap, add the new sample) in each window.
// Reset (async, active low) clears running sums, sample count and pipeline
// valid bits; the history shift line is not reset, it is refilled before use.
module multi_window_trailing_average_top
	import mwta_pkg::*;
	#(
		parameter int LONGEST_WINDOW = 120,
		parameter int SAMPLE_BITS    = 32
	)
	(
		input logic       clk,
		input logic       arst_n,
		mwta_in_if.sink   stream,
		mwta_out_if.source result
	);

	localparam int HB = (SAMPLE_BITS < SAMPLE_IN_BITS) ? SAMPLE_BITS : SAMPLE_IN_BITS;
	localparam int CB = $clog2(LONGEST_WINDOW + 1);
	localparam int NS = DIV_STAGES + 1;

	logic                       in_fire;
	logic [NS-1:0]              adv;
	logic [NS-1:0]              v_q;

	logic [HB-1:0]              hist_q [LONGEST_WINDOW];
	logic [HB-1:0]              x_hist;
	logic signed [SUM_BITS-1:0] x_ext;
	logic [CB-1:0]              seen_q;
	logic [CB-1:0]              seen_eff;

	logic signed [SUM_BITS-1:0] sums_q  [NUM_WINDOWS];
	logic signed [SUM_BITS-1:0] base    [NUM_WINDOWS];
	logic signed [SUM_BITS-1:0] sum_nxt [NUM_WINDOWS];
	logic [NUM_WINDOWS-1:0]     full;

	logic signed [SUM_BITS-1:0] sums_s1 [NUM_WINDOWS];
	logic [NUM_WINDOWS-1:0]     mask_s1;

	logic signed [AVG_BITS-1:0] avg_lane [NUM_WINDOWS];
	logic [NUM_WINDOWS-1:0]     full_lane;

	// Handshake: each stage advances when empty or when the next one advances
	always_comb begin
		adv[NS-1] = !v_q[NS-1] || result.ready;
		for (int i = NS - 2; i >= 0; i--) begin
			adv[i] = !v_q[i] || adv[i+1];
		end
	end

	assign stream.ready = adv[0];
	assign in_fire      = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0]) begin
				v_q[0] <= stream.valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (adv[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	// Sample wrapped to the history width
	assign x_hist   = stream.sample[HB-1:0];
	assign x_ext    = SUM_BITS'(signed'(x_hist));
	assign seen_eff = stream.series_start ? '0 : seen_q;

	// History shift line, newest sample at tap 0
	always_ff @(posedge clk) begin
		if (in_fire) begin
			hist_q[0] <= x_hist;
			for (int i = 1; i < LONGEST_WINDOW; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	// Per-window fill test and running-sum update
	for (genvar k = 0; k < NUM_WINDOWS; k++) begin : g_win
		localparam int W   = WINDOW_LEN[k];
		localparam bit EN  = (W <= LONGEST_WINDOW);
		localparam int TAP = EN ? W - 1 : 0;

		logic signed [SUM_BITS-1:0] tap_ext;

		assign tap_ext    = SUM_BITS'(signed'(hist_q[TAP]));
		assign full[k]    = EN && (int'(seen_eff) >= W);
		assign base[k]    = stream.series_start ? '0 : sums_q[k];
		assign sum_nxt[k] = base[k] - (full[k] ? tap_ext : '0) + x_ext;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sums_q[k] <= '0;
			end else if (in_fire && EN) begin
				sums_q[k] <= sum_nxt[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[0]) begin
				sums_s1[k] <= base[k];
				mask_s1[k] <= full[k];
			end
		end

		mwta_div_lane #(
			.DIVISOR (W)
		) u_div (
			.clk      (clk),
			.stage_en (adv[NS-1:1]),
			.sum      (sums_s1[k]),
			.full     (mask_s1[k]),
			.avg      (avg_lane[k]),
			.avg_full (full_lane[k])
		);
	end

	// Prior-sample count, saturating at the longest window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (in_fire) begin
			if (seen_eff < CB'(LONGEST_WINDOW)) begin
				seen_q <= seen_eff + 1'b1;
			end else begin
				seen_q <= seen_eff;
			end
		end
	end

	// Result channel
	assign result.valid     = v_q[NS-1];
	assign result.avg_w3    = avg_lane[0];
	assign result.avg_w5    = avg_lane[1];
	assign result.avg_w10   = avg_lane[2];
	assign result.avg_w30   = avg_lane[3];
	assign result.avg_w60   = avg_lane[4];
	assign result.avg_w120  = avg_lane[5];
	assign result.full_mask = full_lane;

	// Checks
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CB'(LONGEST_WINDOW))
		else $error("sample count above longest window");

	a_series_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && stream.series_start |=> seen_q == CB'(1))
		else $error("series start did not restart the sample count");

	a_mask_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[0] |-> ((mask_s1 & (mask_s1 + 1'b1)) == '0))
		else $error("longer window full before a shorter one");

	a_empty_avg: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.full_mask[0] |-> result.avg_w3 == '0)
		else $error("average of an unfilled window is not zero");

endmodule

@@ dv/multi_window_trailing_average_top_tb.sv @@
`timescale 1ns / 1ps

module multi_window_trailing_average_top_tb;
	import mwta_pkg::*;

	localparam int LONGEST        = 120;
	localparam int SMP_BITS       = 32;
	localparam int LATENCY        = 6;
	localparam int MAX_GAP        = 13;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT   = 10;
	localparam int RANDOM_ITEMS   = 1330;
	localparam int BURST_ITEMS    = 200;

	typedef logic signed [SAMPLE_IN_BITS-1:0] sample_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_IN_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_IN_BITS-1){1'b0}}};

	// One result transaction: six window means plus the full mask
	typedef struct packed {
		logic [NUM_WINDOWS-1:0][AVG_BITS-1:0] avg;
		logic [NUM_WINDOWS-1:0]               full_mask;
	} trailing_avg_t;

	// Content profile of one random series
	typedef enum int {
		SHAPE_FULL,
		SHAPE_NEAR_MAX,
		SHAPE_NEAR_MIN,
		SHAPE_TINY,
		SHAPE_SEESAW
	} sample_shape_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mwta_in_if  stream ();
	mwta_out_if result ();

	multi_window_trailing_average_top #(
		.LONGEST_WINDOW(LONGEST),
		.SAMPLE_BITS   (SMP_BITS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.stream(stream),
		.result(result)
	);

	always #4 clk = ~clk;

	// Predictor state: sample ring, running window sums, series fill level
	longint        hist_ring [LONGEST];
	longint        run_sum [NUM_WINDOWS];
	int            prior_count;
	int            ring_slot;
	trailing_avg_t expected_avgs [$];

	// Traffic control shared between the stimulus and the result sink
	bit   src_idle_en     = 1'b0;
	bit   snk_idle_en     = 1'b0;
	bit   want_long_hold  = 1'b0;
	bit   long_hold_taken = 1'b0;
	int   sink_wait       = 0;
	logic sink_ready      = 1'b0;
	int   fail_count      = 0;
	int   result_idx      = 0;
	int   stall_cycles    = 0;

	assign result.ready = sink_ready;

	function automatic void clear_predictor();
		int k;
		for (k = 0; k < LONGEST; k++)
			hist_ring[k] = 0;
		for (k = 0; k < NUM_WINDOWS; k++)
			run_sum[k] = 0;
		prior_count = 0;
		ring_slot   = 0;
	endfunction

	// Means of the prior samples, then fold the new sample into the sums
	function automatic trailing_avg_t advance_averages(input sample_t raw, input logic restart);
		trailing_avg_t res;
		longint        x;
		int            w;
		int            k;
		x = raw;
		if (SMP_BITS < SAMPLE_IN_BITS)
			x = (x <<< (64 - SMP_BITS)) >>> (64 - SMP_BITS);
		if (restart)
			clear_predictor();
		res = '0;
		for (k = 0; k < NUM_WINDOWS; k++) begin
			w = WINDOW_LEN[k];
			if (w <= LONGEST && prior_count >= w) begin
				// signed divide truncates toward zero
				res.avg[k]       = AVG_BITS'(run_sum[k] / longint'(w));
				res.full_mask[k] = 1'b1;
			end
		end
		for (k = 0; k < NUM_WINDOWS; k++) begin
			w = WINDOW_LEN[k];
			if (w <= LONGEST) begin
				if (prior_count >= w)
					run_sum[k] -= hist_ring[(ring_slot + LONGEST - w) % LONGEST];
				run_sum[k] += x;
			end
		end
		hist_ring[ring_slot] = x;
		ring_slot = (ring_slot + 1) % LONGEST;
		if (prior_count < LONGEST)
			prior_count++;
		return res;
	endfunction

	function automatic sample_t shaped_sample(input sample_shape_t shape, input int idx);
		case (shape)
			SHAPE_NEAR_MAX: return SAMPLE_MAX - sample_t'($urandom_range(0, 255));
			SHAPE_NEAR_MIN: return SAMPLE_MIN + sample_t'($urandom_range(0, 255));
			SHAPE_TINY:     return sample_t'($urandom_range(0, 16)) - sample_t'(8);
			SHAPE_SEESAW:   return idx[0] ? SAMPLE_MAX : SAMPLE_MIN;
			default:        return sample_t'($urandom());
		endcase
	endfunction

	// Offer one sample, wait for its transaction, queue the expected means
	task automatic send_sample(input sample_t value, input logic restart);
		int gap;
		gap = src_idle_en ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			stream.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream.valid        <= 1'b1;
		stream.sample       <= value;
		stream.series_start <= restart;
		do @(posedge clk); while (!stream.ready);
		expected_avgs = {expected_avgs, advance_averages(value, restart)};
	endtask

	task automatic drain_results();
		stream.valid <= 1'b0;
		while (expected_avgs.size() != 0)
			@(posedge clk);
		repeat (4 * LATENCY) @(posedge clk);
	endtask

	// Saturated samples fill the 3, 5 and 10 windows; negative runs check truncation toward zero
	task automatic test_directed_extremes();
		int k;
		send_sample(SAMPLE_MAX, 1'b1);
		for (k = 0; k < 3; k++)
			send_sample(SAMPLE_MAX, 1'b0);
		for (k = 0; k < 5; k++)
			send_sample(SAMPLE_MIN, 1'b0);
		send_sample(sample_t'(0), 1'b0);
		send_sample(sample_t'(-1), 1'b0);
		send_sample(sample_t'(-1), 1'b0);
		send_sample(sample_t'(-2), 1'b0);
		send_sample(sample_t'(1), 1'b0);
		send_sample(sample_t'(3), 1'b0);
	endtask

	// Restart with live history, then back-to-back restarts
	task automatic test_series_restart();
		send_sample(sample_t'(5), 1'b1);
		send_sample(sample_t'(-7), 1'b0);
		send_sample(sample_t'(-7), 1'b0);
		send_sample(sample_t'(-8), 1'b0);
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample(SAMPLE_MIN, 1'b1);
	endtask

	// Mostly full-length series with shaped content, some short ones and stray restarts
	task automatic test_random_series();
		int            sent;
		int            series_len;
		int            k;
		sample_shape_t shape;
		logic          restart;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			series_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20)
				: $urandom_range(LONGEST + 1, LONGEST + 80);
			shape = sample_shape_t'($urandom_range(0, 4));
			src_idle_en = ($urandom_range(0, 3) != 0);
			snk_idle_en <= ($urandom_range(0, 3) != 0);
			for (k = 0; k < series_len; k++) begin
				restart = (k == 0) || ($urandom_range(0, 99) < 2);
				send_sample(shaped_sample(shape, k), restart);
			end
			sent += series_len;
		end
	endtask

	// Sink holds off for a long stretch while the stream keeps coming
	task automatic test_output_backpressure();
		int k;
		src_idle_en = 1'b0;
		snk_idle_en <= 1'b0;
		want_long_hold <= 1'b1;
		for (k = 0; k < BURST_ITEMS; k++)
			send_sample(sample_t'($urandom()), k == 0);
	endtask

	// Result sink: random ready gaps, one long hold, compare against the oldest expectation
	always @(posedge clk) begin : result_sink
		trailing_avg_t got;
		trailing_avg_t want;
		int            k;
		if (!arst_n) begin
			sink_ready      <= 1'b0;
			sink_wait       = 0;
			long_hold_taken = 1'b0;
		end else begin
			if (sink_wait > 0)
				sink_wait--;
			if (result.valid && result.ready) begin
				got.avg[0]    = result.avg_w3;
				got.avg[1]    = result.avg_w5;
				got.avg[2]    = result.avg_w10;
				got.avg[3]    = result.avg_w30;
				got.avg[4]    = result.avg_w60;
				got.avg[5]    = result.avg_w120;
				got.full_mask = result.full_mask;
				if (expected_avgs.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("result %0d arrived with nothing outstanding", result_idx);
				end else begin
					want = expected_avgs.pop_front();
					for (k = 0; k < NUM_WINDOWS; k++) begin
						if (got.avg[k] !== want.avg[k]) begin
							fail_count++;
							if (fail_count <= REPORT_LIMIT)
								$display("result %0d avg_w%0d: expected %0d, got %0d",
									result_idx, WINDOW_LEN[k],
									$signed(want.avg[k]), $signed(got.avg[k]));
						end
					end
					if (got.full_mask !== want.full_mask) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("result %0d full_mask: expected %b, got %b",
								result_idx, want.full_mask, got.full_mask);
					end
				end
				result_idx++;
				sink_wait = snk_idle_en ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (want_long_hold && !long_hold_taken) begin
				sink_wait       = LONG_HOLD;
				long_hold_taken = 1'b1;
			end
			sink_ready <= (sink_wait == 0);
		end
	end

	// Watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((stream.valid && stream.ready) || (result.valid && result.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		stream.valid        <= 1'b0;
		stream.sample       <= '0;
		stream.series_start <= 1'b0;
		clear_predictor();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_series_restart();
		test_random_series();
		test_output_backpressure();
		drain_results();
		if (fail_count == 0 && expected_avgs.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/mwta_pkg.sv
hw/rtl/mwta_if.sv
hw/rtl/mwta_div_lane.sv
hw/rtl/multi_window_trailing_average_top.sv
dv/multi_window_trailing_average_top_tb.sv
